/* hdl/wrr_pkg.sv */
// shared constants and types for the weighted round robin selector
`default_nettype none

package wrr_pkg;

	localparam int NUM_QUEUES   = 3;
	localparam int WEIGHT_BITS  = 8;
	localparam int NUM_REGS     = 3;
	localparam int CFG_W        = 8;
	localparam int REG_IDX_W    = 2;
	localparam int HANDLE_W     = 32;
	localparam int QIDX_W       = 2;
	localparam int PTR_W        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CW_W         = WEIGHT_BITS + 1;
	localparam int SEARCH_LIMIT = 4 * NUM_QUEUES + 4;
	localparam int STEP_W       = $clog2(SEARCH_LIMIT + 1);
	// queues that actually own a weight register
	localparam int NREG_EFF     = (NUM_REGS < NUM_QUEUES) ? NUM_REGS : NUM_QUEUES;

	// register index of the first weight, the rest follow in queue order
	localparam int REG_WEIGHT_FIRST = 0;

	typedef logic [NUM_QUEUES-1:0][WEIGHT_BITS-1:0] weight_vec_t;

	typedef struct packed {
		weight_vec_t            weight;
		logic [WEIGHT_BITS-1:0] wgcd;
		logic [WEIGHT_BITS-1:0] wmax;
	} wcfg_t;

	typedef struct packed {
		logic [QIDX_W-1:0] qidx;
		logic              none;
	} wrr_res_t;

endpackage

`default_nettype wire

/* hdl/wrr_derive.sv */
// weight registers with an iterative gcd and max unit recomputed after each write
`default_nettype none

module wrr_derive (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [wrr_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [wrr_pkg::CFG_W-1:0]    wr_data,
	output wrr_pkg::wcfg_t                    wcfg,
	output logic                              busy
);
	import wrr_pkg::*;

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_LOAD = 3'b010,
		D_RUN  = 3'b100
	} dstate_t;

	dstate_t                   state_q;
	weight_vec_t               weight_q;
	weight_vec_t               weight_n;
	weight_vec_t               sh_q;
	logic [NUM_QUEUES-1:0]     wr_hit;
	logic                      wr_any;
	logic [PTR_W-1:0]          idx_q;
	logic [WEIGHT_BITS-1:0]    gcd_q;
	logic [WEIGHT_BITS-1:0]    max_q;
	logic [WEIGHT_BITS-1:0]    a_q;
	logic [WEIGHT_BITS-1:0]    b_q;
	logic [WEIGHT_BITS-1:0]    g_acc_q;
	logic [WEIGHT_BITS-1:0]    m_acc_q;

	always_comb begin
		weight_n = weight_q;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			wr_hit[i] = (i < NREG_EFF) && wr_en &&
				(wr_index == REG_IDX_W'(REG_WEIGHT_FIRST + i));
			if (wr_hit[i]) begin
				weight_n[i] = WEIGHT_BITS'(wr_data);
			end
		end
	end

	assign wr_any = |wr_hit;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			idx_q   <= '0;
			gcd_q   <= WEIGHT_BITS'(1);
			max_q   <= WEIGHT_BITS'(1);
			for (int i = 0; i < NUM_QUEUES; i++) begin
				weight_q[i] <= (i < NREG_EFF) ? WEIGHT_BITS'(1) : '0;
			end
		end else if (wr_any) begin
			// a new write restarts the derivation from queue zero
			weight_q <= weight_n;
			state_q  <= D_LOAD;
			idx_q    <= '0;
		end else begin
			unique case (state_q)
				D_LOAD: begin
					state_q <= D_RUN;
				end
				D_RUN: begin
					if (b_q == '0) begin
						if (idx_q == PTR_W'(NUM_QUEUES - 1)) begin
							gcd_q   <= a_q;
							max_q   <= m_acc_q;
							state_q <= D_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= D_LOAD;
						end
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// subtractive euclid datapath, one subtract or swap per cycle
	always_ff @(posedge clk) begin
		if (wr_any) begin
			sh_q    <= weight_n;
			g_acc_q <= '0;
			m_acc_q <= '0;
		end else begin
			unique case (state_q)
				D_LOAD: begin
					a_q  <= g_acc_q;
					b_q  <= sh_q[0];
					sh_q <= sh_q >> WEIGHT_BITS;
					if (sh_q[0] > m_acc_q) begin
						m_acc_q <= sh_q[0];
					end
				end
				D_RUN: begin
					if (b_q == '0) begin
						g_acc_q <= a_q;
					end else if (a_q >= b_q) begin
						a_q <= a_q - b_q;
					end else begin
						a_q <= b_q;
						b_q <= a_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign wcfg.weight = weight_q;
	assign wcfg.wgcd   = gcd_q;
	assign wcfg.wmax   = max_q;
	assign busy        = (state_q != D_IDLE);

endmodule

`default_nettype wire

/* hdl/wrr_search.sv */
// queue search sequencer: one pointer step and weight compare per cycle
`default_nettype none

module wrr_search (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      out_free,
	input  wrr_pkg::wcfg_t wcfg,
	output logic           busy,
	output logic           done,
	output wrr_pkg::wrr_res_t res
);
	import wrr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_EMIT = 3'b100
	} sstate_t;

	sstate_t                  state_q;
	logic [PTR_W-1:0]         ptr_q;
	logic signed [CW_W-1:0]   cw_q;
	logic [PTR_W-1:0]         ptr_w_q;
	logic signed [CW_W-1:0]   cw_w_q;
	logic [STEP_W-1:0]        cnt_q;
	logic [QIDX_W-1:0]        res_qidx_q;
	logic                     res_none_q;

	logic                     wrap;
	logic [PTR_W-1:0]         ptr_nx;
	logic signed [CW_W-1:0]   cw_dec;
	logic signed [CW_W-1:0]   cw_step;
	logic [WEIGHT_BITS-1:0]   w_sel;
	logic                     hit;

	always_comb begin
		wrap   = (ptr_w_q == PTR_W'(NUM_QUEUES - 1));
		ptr_nx = wrap ? '0 : ptr_w_q + 1'b1;
		cw_dec = cw_w_q - $signed({1'b0, wcfg.wgcd});
		// lower by the gcd on wrap, reload with the max once it drops to zero or below
		if (wrap) begin
			cw_step = (cw_dec <= 0) ? $signed({1'b0, wcfg.wmax}) : cw_dec;
		end else begin
			cw_step = cw_w_q;
		end
		w_sel = wcfg.weight[ptr_nx];
		hit   = ($signed({1'b0, w_sel}) >= cw_step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ptr_q      <= PTR_W'(NUM_QUEUES - 1);
			cw_q       <= '0;
			ptr_w_q    <= '0;
			cw_w_q     <= '0;
			cnt_q      <= '0;
			res_qidx_q <= '0;
			res_none_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ptr_w_q <= ptr_q;
						cw_w_q  <= cw_q;
						cnt_q   <= '0;
						if (wcfg.wmax == '0) begin
							res_qidx_q <= '0;
							res_none_q <= 1'b1;
							state_q    <= S_EMIT;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					ptr_w_q <= ptr_nx;
					cw_w_q  <= cw_step;
					cnt_q   <= cnt_q + 1'b1;
					if (hit) begin
						ptr_q      <= ptr_nx;
						cw_q       <= cw_step;
						res_qidx_q <= QIDX_W'(ptr_nx);
						res_none_q <= 1'b0;
						state_q    <= S_EMIT;
					end else if (cnt_q == STEP_W'(SEARCH_LIMIT - 1)) begin
						// search bound hit: report nothing selected, state kept
						res_qidx_q <= '0;
						res_none_q <= 1'b1;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_EMIT) && out_free;
	assign res.qidx = res_qidx_q;
	assign res.none = res_none_q;

endmodule

`default_nettype wire

/* hdl/weighted_round_robin_selector.sv */
// Interleaved weighted round robin selector over three queues (gcd variant).
// Input channel: in_valid/in_stall with packet_handle; a transaction is taken
// when in_valid is high and in_stall is low. Output channel: out_valid/out_stall
// with handle_out, queue_index and no_queue, one result per input transaction.
// Weights are written through wr_en/wr_index/wr_data; index 0..2 selects the
// weight of queue 0..2, other indexes are ignored.
// After each weight write the gcd and max are rebuilt by a subtractive euclid
// unit: per queue a load step followed by subtract or swap steps; in_stall
// stays high during that time.
// Each packet passes an accept step, a search in the shared search unit (one
// pointer step and compare per cycle, none when every weight is zero) and a
// load of the output register.
// The next packet may be taken while the previous result waits in the output
// register; its search holds in the emit step until the register frees up.
// When the receiver stalls, the result stays on the outputs unchanged.
// Reset gives weights of 1, gcd and max of 1, pointer at the last queue and a
// current weight of zero; no transaction is pending after reset.
`default_nettype none

module weighted_round_robin_selector (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [wrr_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [wrr_pkg::CFG_W-1:0]     wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [wrr_pkg::HANDLE_W-1:0]  packet_handle,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [wrr_pkg::HANDLE_W-1:0]       handle_out,
	output logic [wrr_pkg::QIDX_W-1:0]         queue_index,
	output logic                               no_queue
);
	import wrr_pkg::*;

	wcfg_t                 wcfg;
	wrr_res_t              res;
	logic                  derive_busy;
	logic                  search_busy;
	logic                  search_done;
	logic                  in_acc;
	logic                  out_free;
	logic [HANDLE_W-1:0]   handle_q;
	logic                  out_valid_q;
	logic [HANDLE_W-1:0]   handle_out_q;
	logic [QIDX_W-1:0]     queue_index_q;
	logic                  no_queue_q;

	assign in_stall = derive_busy | search_busy;
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	wrr_derive u_derive (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.wcfg     (wcfg),
		.busy     (derive_busy)
	);

	wrr_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.out_free (out_free),
		.wcfg     (wcfg),
		.busy     (search_busy),
		.done     (search_done),
		.res      (res)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			handle_q <= packet_handle;
		end
		if (search_done) begin
			handle_out_q  <= handle_q;
			queue_index_q <= res.qidx;
			no_queue_q    <= res.none;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (search_done) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign handle_out  = handle_out_q;
	assign queue_index = queue_index_q;
	assign no_queue    = no_queue_q;

endmodule

`default_nettype wire

/* tb/sv/tb_weighted_round_robin_selector.sv */
`timescale 1ns / 1ps
// self-checking testbench for the weighted round robin selector
module tb_weighted_round_robin_selector;
	import wrr_pkg::*;

	localparam int CLK_HIGH          = 6;
	localparam int CLK_LOW           = 6;
	localparam int RESET_CYCLES      = 8;
	localparam int DRAIN_CYCLES      = 24;
	localparam int HOLD_CYCLES       = 300;
	localparam int CYCLE_LIMIT       = 600000;
	localparam int RANDOM_ITEMS      = 150;
	localparam int ITEMS_PER_SETTING = 25;
	localparam int PRINT_LIMIT       = 50;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_SECOND = REG_IDX_W'(REG_WEIGHT_FIRST + 1);
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_THIRD  = REG_IDX_W'(REG_WEIGHT_FIRST + 2);
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_NONE   = REG_IDX_W'(REG_WEIGHT_FIRST + NUM_REGS);

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [QIDX_W-1:0]   qidx;
		logic                none;
	} selection_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 wr_en         = 1'b0;
	logic [REG_IDX_W-1:0] wr_index      = '0;
	logic [CFG_W-1:0]     wr_data       = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [HANDLE_W-1:0]  packet_handle = '0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [HANDLE_W-1:0]  handle_out;
	logic [QIDX_W-1:0]    queue_index;
	logic                 no_queue;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   error_count   = 0;
	int   cycle_count   = 0;
	logic holding       = 1'b0;
	event hold_off_ev;

	// predictor state
	logic [WEIGHT_BITS-1:0] pred_weight [NUM_QUEUES];
	int                     pred_ptr;
	int                     pred_cw;
	int                     pred_gcd;
	int                     pred_max;

	selection_t expected_selections[$];

	weighted_round_robin_selector uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packet_handle(packet_handle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.handle_out   (handle_out),
		.queue_index  (queue_index),
		.no_queue     (no_queue)
	);

	always begin
		clk = 1'b1;
		#(CLK_HIGH);
		clk = 1'b0;
		#(CLK_LOW);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int gcd_pair(input int a, input int b);
		int t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic void rebuild_gcd_max();
		int g;
		int m;
		g = 0;
		m = 0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			g = gcd_pair(g, int'(pred_weight[i]));
			if (int'(pred_weight[i]) > m)
				m = int'(pred_weight[i]);
		end
		pred_gcd = g;
		pred_max = m;
	endfunction

	function automatic void reset_predictor();
		for (int i = 0; i < NUM_QUEUES; i++)
			pred_weight[i] = (i < NUM_REGS) ? WEIGHT_BITS'(1) : '0;
		pred_ptr = NUM_QUEUES - 1;
		pred_cw  = 0;
		rebuild_gcd_max();
	endfunction

	function automatic void apply_weight_write(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		int slot;
		slot = int'(idx) - REG_WEIGHT_FIRST;
		if (slot >= 0 && slot < NUM_REGS && slot < NUM_QUEUES) begin
			pred_weight[slot] = val[WEIGHT_BITS-1:0];
			rebuild_gcd_max();
		end
	endfunction

	function automatic selection_t predict_selection(input logic [HANDLE_W-1:0] h);
		selection_t s;
		int p;
		int c;
		s.handle = h;
		s.qidx   = '0;
		s.none   = 1'b1;
		if (pred_max == 0)
			return s;
		p = pred_ptr;
		c = pred_cw;
		for (int n = 0; n < SEARCH_LIMIT; n++) begin
			p = (p + 1) % NUM_QUEUES;
			// each wrap lowers the round weight, reload once it runs out
			if (p == 0) begin
				c -= pred_gcd;
				if (c <= 0)
					c = pred_max;
			end
			if (int'(pred_weight[p]) >= c) begin
				pred_ptr = p;
				pred_cw  = c;
				s.qidx   = QIDX_W'(p);
				s.none   = 1'b0;
				return s;
			end
		end
		return s;
	endfunction

	function automatic logic [CFG_W-1:0] rand_weight();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return CFG_W'($urandom_range(4, 1));
			default: return CFG_W'($urandom_range(255));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// receiver side stall
	always @(negedge clk) begin
		if (holding)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// long receiver hold-off, counted here
	initial begin
		forever begin
			@(hold_off_ev);
			holding = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding = 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		selection_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_selections.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction, handle %h", handle_out));
			end else begin
				want = expected_selections.pop_front();
				if (handle_out !== want.handle)
					report_mismatch($sformatf("handle_out %h, want %h",
						handle_out, want.handle));
				if (queue_index !== want.qidx)
					report_mismatch($sformatf("queue_index %0d, want %0d (handle %h)",
						queue_index, want.qidx, want.handle));
				if (no_queue !== want.none)
					report_mismatch($sformatf("no_queue %b, want %b (handle %h)",
						no_queue, want.none, want.handle));
			end
		end
	end

	task automatic send_packet(input logic [HANDLE_W-1:0] h);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		packet_handle <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_selections.push_back(predict_selection(h));
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_selections.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_weight(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_all_results();
		// let the last search and any gcd rebuild finish
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		apply_weight_write(idx, val);
	endtask

	task automatic set_weights(input logic [CFG_W-1:0] w0, input logic [CFG_W-1:0] w1,
			input logic [CFG_W-1:0] w2);
		write_weight(REG_IDX_W'(REG_WEIGHT_FIRST), w0);
		write_weight(REG_WEIGHT_SECOND, w1);
		write_weight(REG_WEIGHT_THIRD, w2);
	endtask

	task automatic test_reset_weights();
		send_packet('0);
		send_packet('1);
		send_packet(32'hA5A5_A5A5);
		send_packet(32'h5A5A_5A5A);
	endtask

	task automatic test_weight_extremes();
		set_weights(8'hFF, 8'hFF, 8'hFF);
		repeat (3) send_packet($urandom());
		write_weight(REG_WEIGHT_SECOND, 8'h00);
		write_weight(REG_WEIGHT_THIRD, 8'h00);
		repeat (2) send_packet($urandom());
		// out-of-range register index must be ignored
		write_weight(REG_WEIGHT_NONE, 8'h00);
		send_packet($urandom());
		write_weight(REG_IDX_W'(REG_WEIGHT_FIRST), 8'h00);
		send_packet('1);
		send_packet('0);
		write_weight(REG_WEIGHT_THIRD, 8'hFF);
		repeat (2) send_packet($urandom());
	endtask

	task automatic test_weight_shrink();
		// round weight left above the new maximum has to count down first
		set_weights(8'd200, 8'd100, 8'd50);
		repeat (2) send_packet($urandom());
		set_weights(8'd3, 8'd2, 8'd1);
		repeat (4) send_packet($urandom());
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_weights(8'd3, 8'd2, 8'd1);
		-> hold_off_ev;
		repeat (12) send_packet($urandom());
		wait_all_results();
		repeat (6) send_packet($urandom());
		wait_all_results();
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % ITEMS_PER_SETTING == 0) begin
				// sometimes one register only, the unused index included
				if ($urandom_range(3) == 0)
					write_weight(REG_IDX_W'($urandom_range(NUM_REGS)), rand_weight());
				else
					set_weights(rand_weight(), rand_weight(), rand_weight());
			end
			send_packet($urandom());
		end
	endtask

	initial begin
		reset_predictor();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_weights();
		test_weight_extremes();
		test_weight_shrink();
		test_backpressure();
		run_random_phase(11, 50);
		run_random_phase(50, 11);
		run_random_phase(0, 0);

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_selections.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* weighted_round_robin_selector.f */
hdl/wrr_pkg.sv
hdl/wrr_derive.sv
hdl/wrr_search.sv
hdl/weighted_round_robin_selector.sv
tb/sv/tb_weighted_round_robin_selector.sv
